[hw/rtl/smfe_pkg.sv]
// Package: constants, result type and character helpers for the splice motif extractor.
package smfe_pkg;

    // Records longer than this get code_valid low from this position on
    localparam logic [7:0] SEQ_LEN = 8'd60;

    // Character history depth and window width in bits
    localparam int HIST_DEPTH = 8;
    localparam int WIN_W      = (HIST_DEPTH + 1) * 8;

    // Base codes, index in ACTGDNSR
    localparam logic [2:0] CODE_A = 3'd0;
    localparam logic [2:0] CODE_C = 3'd1;
    localparam logic [2:0] CODE_T = 3'd2;
    localparam logic [2:0] CODE_G = 3'd3;
    localparam logic [2:0] CODE_D = 3'd4;
    localparam logic [2:0] CODE_N = 3'd5;
    localparam logic [2:0] CODE_S = 3'd6;
    localparam logic [2:0] CODE_R = 3'd7;

    // Motifs, first character in the most significant byte
    localparam logic [71:0] EI_MOTIF_0 = "AAGGTAAGT";
    localparam logic [71:0] EI_MOTIF_1 = "AAGGTGAGT";
    localparam logic [71:0] EI_MOTIF_2 = "CAGGTAAGT";
    localparam logic [71:0] EI_MOTIF_3 = "CAGGTGAGT";
    localparam logic [31:0] IE_MOTIF_0 = "CAGG";
    localparam logic [31:0] IE_MOTIF_1 = "TAGG";
    localparam logic [23:0] STOP_TAA   = "TAA";
    localparam logic [23:0] STOP_TAG   = "TAG";
    localparam logic [23:0] STOP_TGA   = "TGA";

    // Motif flag bit positions
    localparam int FLAG_EI   = 0;
    localparam int FLAG_IE   = 1;
    localparam int FLAG_STOP = 2;

    typedef struct packed {
        logic [2:0] base_code;
        logic       code_valid;
        logic       bad_char;
        logic       record_done;
        logic       exon_intron_seen;
        logic       intron_exon_seen;
        logic       stop_codon_seen;
    } t_smfe_result;

    // Map an ASCII character to its base code; bit 3 set means unknown
    function automatic logic [3:0] encode_char(input logic [7:0] c);
        logic [3:0] res;
        case (c)
            "A":     res = {1'b0, CODE_A};
            "C":     res = {1'b0, CODE_C};
            "T":     res = {1'b0, CODE_T};
            "G":     res = {1'b0, CODE_G};
            "D":     res = {1'b0, CODE_D};
            "N":     res = {1'b0, CODE_N};
            "S":     res = {1'b0, CODE_S};
            "R":     res = {1'b0, CODE_R};
            default: res = {1'b1, CODE_A};
        endcase
        return res;
    endfunction

    // Match motifs that end on the newest character of the window
    function automatic logic [2:0] match_motifs(input logic [WIN_W-1:0] win);
        logic [2:0] hit;
        hit = '0;
        hit[FLAG_EI]   = (win[71:0] == EI_MOTIF_0) || (win[71:0] == EI_MOTIF_1) ||
                         (win[71:0] == EI_MOTIF_2) || (win[71:0] == EI_MOTIF_3);
        hit[FLAG_IE]   = (win[31:0] == IE_MOTIF_0) || (win[31:0] == IE_MOTIF_1);
        hit[FLAG_STOP] = (win[23:0] == STOP_TAA) || (win[23:0] == STOP_TAG) ||
                         (win[23:0] == STOP_TGA);
        return hit;
    endfunction

endpackage

[hw/rtl/smfe_if.sv]
// Interfaces: character input channel and feature result channel.
interface smfe_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] seq_char;
    logic       end_of_record;

    modport source (output valid, output seq_char, output end_of_record, input ready);
    modport sink   (input valid, input seq_char, input end_of_record, output ready);
endinterface

interface smfe_out_if;
    logic       valid;
    logic       ready;
    logic [2:0] base_code;
    logic       code_valid;
    logic       bad_char;
    logic       record_done;
    logic       exon_intron_seen;
    logic       intron_exon_seen;
    logic       stop_codon_seen;

    modport source (output valid, output base_code, output code_valid, output bad_char,
                    output record_done, output exon_intron_seen, output intron_exon_seen,
                    output stop_codon_seen, input ready);
    modport sink   (input valid, input base_code, input code_valid, input bad_char,
                    input record_done, input exon_intron_seen, input intron_exon_seen,
                    input stop_codon_seen, output ready);
endinterface

[hw/rtl/splice_motif_feature_extractor_unit.sv]
// Top level: splice motif feature extractor with registered result stage.
// An accepted input transaction shows its result on the output in the next cycle.
// Throughput: one character per cycle unless the output stalls; the motif compares
//   run against the 8-character history and the current character.
// Reset (synchronous, active low) empties the output register and clears history,
//   motif flags and position count; no clearing pass is needed.
module splice_motif_feature_extractor_unit
    import smfe_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    smfe_in_if.sink     i_in_ch,
    smfe_out_if.source  o_out_ch
);

    logic [7:0]     r_hist [HIST_DEPTH];
    logic [7:0]     n_hist [HIST_DEPTH];
    logic [2:0]     r_flags;
    logic [2:0]     n_flags;
    logic [7:0]     r_pos;
    logic [7:0]     n_pos;
    logic           r_out_valid;
    logic           n_out_valid;
    t_smfe_result   r_res;
    t_smfe_result   n_res;

    logic           in_fire;
    logic [WIN_W-1:0] win;
    logic [3:0]     enc;
    logic [2:0]     flags_now;

    // Accept when the result register is empty or drains this cycle
    assign i_in_ch.ready = !r_out_valid || o_out_ch.ready;
    assign in_fire       = i_in_ch.valid && i_in_ch.ready;

    // Build the window: oldest character in the top byte, current in the bottom
    always_comb begin
        for (int k = 0; k < HIST_DEPTH; k++) begin
            win[(k+1)*8 +: 8] = r_hist[k];
        end
        win[7:0] = i_in_ch.seq_char;
    end

    assign enc       = encode_char(i_in_ch.seq_char);
    assign flags_now = r_flags | match_motifs(win);

    // Form the result
    always_comb begin
        n_res.base_code        = enc[2:0];
        n_res.code_valid       = (r_pos < SEQ_LEN);
        n_res.bad_char         = enc[3];
        n_res.record_done      = i_in_ch.end_of_record;
        n_res.exon_intron_seen = i_in_ch.end_of_record && flags_now[FLAG_EI];
        n_res.intron_exon_seen = i_in_ch.end_of_record && flags_now[FLAG_IE];
        n_res.stop_codon_seen  = i_in_ch.end_of_record && flags_now[FLAG_STOP];
    end

    // Advance history, flags and position; clear them at the end of a record
    always_comb begin
        n_hist  = r_hist;
        n_flags = r_flags;
        n_pos   = r_pos;
        if (in_fire) begin
            if (i_in_ch.end_of_record) begin
                for (int k = 0; k < HIST_DEPTH; k++) begin
                    n_hist[k] = '0;
                end
                n_flags = '0;
                n_pos   = '0;
            end else begin
                for (int k = HIST_DEPTH - 1; k > 0; k--) begin
                    n_hist[k] = r_hist[k-1];
                end
                n_hist[0] = i_in_ch.seq_char;
                n_flags   = flags_now;
                if (r_pos != 8'hFF) begin
                    n_pos = r_pos + 8'd1;
                end
            end
        end
    end

    // Hold the result until the sink takes it
    always_comb begin
        n_out_valid = r_out_valid;
        if (in_fire) begin
            n_out_valid = 1'b1;
        end else if (o_out_ch.ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < HIST_DEPTH; k++) begin
                r_hist[k] <= '0;
            end
            r_flags     <= '0;
            r_pos       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_hist      <= n_hist;
            r_flags     <= n_flags;
            r_pos       <= n_pos;
            r_out_valid <= n_out_valid;
        end
    end

    // Result payload register
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_res <= n_res;
        end
    end

    // Drive the output channel
    assign o_out_ch.valid            = r_out_valid;
    assign o_out_ch.base_code        = r_res.base_code;
    assign o_out_ch.code_valid       = r_res.code_valid;
    assign o_out_ch.bad_char         = r_res.bad_char;
    assign o_out_ch.record_done      = r_res.record_done;
    assign o_out_ch.exon_intron_seen = r_res.exon_intron_seen;
    assign o_out_ch.intron_exon_seen = r_res.intron_exon_seen;
    assign o_out_ch.stop_codon_seen  = r_res.stop_codon_seen;

endmodule

[hw/rtl/smfe_checker.sv]
// Checker: port-level assertions for the splice motif extractor, bound to the top level.
module smfe_checker (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic       i_in_ready,
    input  logic       i_out_valid,
    input  logic       i_out_ready,
    input  logic [2:0] i_base_code,
    input  logic       i_bad_char,
    input  logic       i_record_done,
    input  logic       i_ei_seen,
    input  logic       i_ie_seen,
    input  logic       i_stop_seen
);

    // Stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_base_code) &&
            $stable(i_record_done))
        else $error("result changed while stalled");

    // Every accepted input transaction shows a result in the next cycle
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> i_out_valid)
        else $error("result missing after accepted transaction");

    // Flags only on the last character of a record
    a_flags_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_record_done |-> !i_ei_seen && !i_ie_seen && !i_stop_seen)
        else $error("motif flag before end of record");

    // Unknown characters carry code zero
    a_bad_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_bad_char |-> i_base_code == 3'd0)
        else $error("unknown character with nonzero code");

    // A held result blocks nothing: input stays open when the sink is ready
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_ready |-> i_in_ready)
        else $error("input stalled while output drains");

endmodule

bind splice_motif_feature_extractor_unit smfe_checker u_smfe_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in_ch.valid),
    .i_in_ready   (i_in_ch.ready),
    .i_out_valid  (o_out_ch.valid),
    .i_out_ready  (o_out_ch.ready),
    .i_base_code  (o_out_ch.base_code),
    .i_bad_char   (o_out_ch.bad_char),
    .i_record_done(o_out_ch.record_done),
    .i_ei_seen    (o_out_ch.exon_intron_seen),
    .i_ie_seen    (o_out_ch.intron_exon_seen),
    .i_stop_seen  (o_out_ch.stop_codon_seen)
);
